[src/lpmr_pkg.sv]
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types and constants of the log-mel patch mean removal block.
// ----------------------------------------------------------------------------
package lpmr_pkg;

   localparam int VALUE_W = 16;                    // Q7.8 sample and feature width
   localparam int FIDX_W  = 10;                    // feature_index port width
   localparam int CFG_W   = 6;                     // frames_in_use register width
   localparam logic [CFG_W-1:0] FRAMES_RESET = 6'd32;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FINISH = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic store;      // write the sample word into the patch and add it to the sum
      logic start_div;  // launch the mean division
      logic emit;       // load the output register and advance the drain position
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic draining;   // patch complete, features being fetched
      logic load_full;  // load count has reached the target
      logic push_fills; // one more push reaches the target
      logic div_done;   // mean is written this cycle
      logic out_free;   // output register can take a word
   } status_type;

endpackage

[src/lpmr_ram.sv]
// ----------------------------------------------------------------------------
// lpmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpmr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 640,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/lpmr_divider.sv]
// ----------------------------------------------------------------------------
// lpmr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpmr_divider #(
   parameter int DIVIDEND_W = 26,
   parameter int DIVISOR_W  = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  rem_nonzero
);

   localparam int CW = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_sub;
   logic                  ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         rem_in = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done        = done_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = |rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

[src/lpmr_datapath.sv]
// ----------------------------------------------------------------------------
// lpmr_datapath
// Patch store, running sum, mean, drain counter and output register.
// ----------------------------------------------------------------------------
module lpmr_datapath #(
   parameter int MAX_FRAMES = 32,
   parameter int MEL_BANDS  = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr,
   input  logic [lpmr_pkg::CFG_W-1:0]          csr_frames_in_use,
   input  logic signed [lpmr_pkg::VALUE_W-1:0] req_sample_value,
   input  lpmr_pkg::cmd_type                   cmd,
   output lpmr_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lpmr_pkg::VALUE_W-1:0] rsp_feature_value,
   output logic [lpmr_pkg::FIDX_W-1:0]         rsp_feature_index,
   output logic                                rsp_last_feature
);

   import lpmr_pkg::*;

   localparam int SLOTS  = MAX_FRAMES * MEL_BANDS;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SUM_W  = VALUE_W + CNT_W;

   logic [CFG_W-1:0]          frames_ff;
   logic [CNT_W-1:0]          load_count_ff, load_count_in;
   logic [CNT_W-1:0]          drain_count_ff, drain_count_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [VALUE_W-1:0] mean_ff, mean_in;
   logic                      draining_ff, draining_in;
   logic                      neg_ff;
   logic                      zero_cnt_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic [FIDX_W-1:0]         index_ff;
   logic                      last_ff;

   int                        rows;
   logic [CNT_W-1:0]          target;
   logic [CNT_W:0]            load_plus1;
   logic [SUM_W-1:0]          dividend;
   logic                      div_done;
   logic [SUM_W-1:0]          quotient;
   logic                      rem_nz;
   logic signed [SUM_W:0]     q_ext;
   logic signed [SUM_W:0]     mean_wide;
   logic [VALUE_W-1:0]        rd_data;
   logic signed [VALUE_W:0]   diff;
   logic signed [VALUE_W-1:0] sat;
   logic signed [VALUE_W-1:0] feature;
   logic [CNT_W+FIDX_W-1:0]   index_ext;
   logic                      is_last;
   logic                      out_free;

   // target = min(frames_in_use, MAX_FRAMES) * MEL_BANDS
   always_comb begin
      rows       = (int'(frames_ff) < MAX_FRAMES) ? int'(frames_ff) : MAX_FRAMES;
      target     = CNT_W'(rows * MEL_BANDS);
      load_plus1 = {1'b0, load_count_ff} + 1'b1;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.draining   = draining_ff;
   assign status.load_full  = load_count_ff >= target;
   assign status.push_fills = load_plus1 >= {1'b0, target};
   assign status.div_done   = div_done;
   assign status.out_free   = out_free;

   lpmr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (load_count_ff[ADDR_W-1:0]),
      .wr_data (req_sample_value),
      .rd_addr (drain_count_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign dividend = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   lpmr_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.start_div),
      .dividend    (dividend),
      .divisor     (load_count_ff),
      .done        (div_done),
      .quotient    (quotient),
      .rem_nonzero (rem_nz)
   );

   // floor for a negative sum: -q when exact, -q-1 (= ~q) otherwise
   always_comb begin
      q_ext     = $signed({1'b0, quotient});
      mean_wide = neg_ff ? (rem_nz ? ~q_ext : -q_ext) : q_ext;
   end

   // feature word: buffered value minus mean, saturated; zero past the patch
   always_comb begin
      diff      = $signed({rd_data[VALUE_W-1], rd_data}) - $signed({mean_ff[VALUE_W-1], mean_ff});
      sat       = (diff[VALUE_W] != diff[VALUE_W-1]) ?
                  {diff[VALUE_W], {(VALUE_W-1){~diff[VALUE_W]}}} : diff[VALUE_W-1:0];
      feature   = (drain_count_ff < load_count_ff) ? sat : '0;
      index_ext = {{FIDX_W{1'b0}}, drain_count_ff};
      is_last   = drain_count_ff == CNT_W'(SLOTS - 1);
   end

   always_comb begin
      load_count_in  = load_count_ff;
      drain_count_in = drain_count_ff;
      sum_in         = sum_ff;
      mean_in        = mean_ff;
      draining_in    = draining_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (cmd.store) begin
         load_count_in = load_count_ff + 1'b1;
         sum_in        = sum_ff + SUM_W'(req_sample_value);
      end
      if (div_done) begin
         mean_in        = zero_cnt_ff ? '0 : mean_wide[VALUE_W-1:0];
         draining_in    = 1'b1;
         drain_count_in = '0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (is_last) begin
            draining_in    = 1'b0;
            load_count_in  = '0;
            drain_count_in = '0;
            sum_in         = '0;
         end else begin
            drain_count_in = drain_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff      <= FRAMES_RESET;
         load_count_ff  <= '0;
         drain_count_ff <= '0;
         sum_ff         <= '0;
         mean_ff        <= '0;
         draining_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr) begin
            frames_ff <= csr_frames_in_use;
         end
         load_count_ff  <= load_count_in;
         drain_count_ff <= drain_count_in;
         sum_ff         <= sum_in;
         mean_ff        <= mean_in;
         draining_ff    <= draining_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (cmd.start_div) begin
         neg_ff      <= sum_ff[SUM_W-1];
         zero_cnt_ff <= load_count_ff == '0;
      end
      if (cmd.emit) begin
         value_ff <= feature;
         index_ff <= index_ext[FIDX_W-1:0];
         last_ff  <= is_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_feature_value = value_ff;
   assign rsp_feature_index = index_ff;
   assign rsp_last_feature  = last_ff;

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("output word overwritten before it was taken");

   a_store_loading: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (!draining_ff && load_count_ff < CNT_W'(SLOTS)))
      else $error("patch store written outside the loading phase");

   a_drain_start: assert property (@(posedge clock) disable iff (reset)
      $rose(draining_ff) |-> $past(div_done))
      else $error("draining began without a finished mean");

endmodule

[src/lpmr_ctrl.sv]
// ----------------------------------------------------------------------------
// lpmr_ctrl
// Sequencer: takes request words, starts the mean division, paces emits.
// ----------------------------------------------------------------------------
module lpmr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  lpmr_pkg::status_type status,
   output lpmr_pkg::cmd_type    cmd
);

   import lpmr_pkg::*;

   state_type state_ff, state_in;
   logic      pend_emit_ff, pend_emit_in;
   logic      accept;
   logic      push;
   logic      fetch;

   always_comb begin
      accept       = req_valid && (state_ff == ST_IDLE);
      push         = accept && (req_op == OP_PUSH);
      fetch        = accept && (req_op == OP_FETCH);
      state_in     = state_ff;
      pend_emit_in = pend_emit_ff;
      cmd.store     = push && !status.draining && !status.load_full;
      cmd.start_div = state_ff == ST_FINISH;
      cmd.emit      = (state_ff == ST_EMIT) && status.out_free;
      case (state_ff)
         ST_IDLE: begin
            if (push && !status.draining && (status.load_full || status.push_fills)) begin
               state_in     = ST_FINISH;
               pend_emit_in = 1'b0;
            end else if (fetch && status.draining) begin
               state_in = ST_EMIT;
            end else if (fetch && status.load_full) begin
               state_in     = ST_FINISH;
               pend_emit_in = 1'b1;
            end
         end
         ST_FINISH: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = pend_emit_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_emit_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_emit_ff <= pend_emit_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;

endmodule

[src/logmel_patch_mean_removal.sv]
// ----------------------------------------------------------------------------
// logmel_patch_mean_removal
// Buffers one patch of log-mel values, removes its mean and streams features.
// ----------------------------------------------------------------------------
// Usage: push a patch of min(frames_in_use, MAX_FRAMES) * MEL_BANDS Q7.8 words
// (op 0), frame-major, then fetch (op 1) MAX_FRAMES * MEL_BANDS features; each
// fetch returns one word, the stored value minus the floored patch mean,
// saturated, or zero for slots past the patch, and the last one is flagged.
// A fetch during draining passes through the emit state, where the
// registered read of the patch RAM is loaded into the output register once
// that register is free. Completing a patch (the last push, or a fetch once
// the patch is full) runs the restoring divider, one quotient bit per cycle
// over the SUM_W-bit sum, where SUM_W = 16 + clog2(MAX_FRAMES*MEL_BANDS + 1):
// 26 bits at the default sizes. No request word is taken while it runs. The
// output register holds a finished word while new request words are taken; a
// fetch waits for it to drain. There is no clearing pass after reset. Write
// csr_frames_in_use only while idle.
// ----------------------------------------------------------------------------
module logmel_patch_mean_removal #(
   parameter int MAX_FRAMES = 32,
   parameter int MEL_BANDS  = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lpmr_pkg::CFG_W-1:0]          csr_frames_in_use,
   // request words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic signed [lpmr_pkg::VALUE_W-1:0] req_sample_value,
   // feature words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lpmr_pkg::VALUE_W-1:0] rsp_feature_value,
   output logic [lpmr_pkg::FIDX_W-1:0]         rsp_feature_index,
   output logic                                rsp_last_feature
);

   import lpmr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // the register is always writable
   assign csr_ready = 1'b1;

   lpmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   lpmr_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .MEL_BANDS  (MEL_BANDS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr            (csr_valid && csr_ready),
      .csr_frames_in_use (csr_frames_in_use),
      .req_sample_value  (req_sample_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_feature_value (rsp_feature_value),
      .rsp_feature_index (rsp_feature_index),
      .rsp_last_feature  (rsp_last_feature)
   );

endmodule
